/* hw/rtl/fati_pkg.sv */
package fati_pkg;

  localparam int COLUMNS = 256;
  localparam int COL_AW  = $clog2(COLUMNS);
  localparam int POS_W   = 11;
  localparam int KIND_W  = 4;
  localparam int INDEX_W = 24;
  localparam int ACC_W   = 26;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 64;

  localparam logic [KIND_W-1:0]  KIND_NULL = 4'd11;
  localparam logic [ACC_W-1:0]   INDEX_MAX = ACC_W'(24'hFF_FFFF);

  localparam logic       CMD_WRITE  = 1'b0;
  localparam logic       CMD_LOOKUP = 1'b1;
  localparam logic [1:0] BLK_LOGIC  = 2'd0;
  localparam logic [1:0] BLK_RAM    = 2'd1;

  localparam logic [CFG_IW-1:0] CFG_TYPE_LO    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_TYPE_HI    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_RAM_FRAMES = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ROW_FRAMES = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_RAM_OFFSET = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_RAM_ROWS   = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_NULL_AREAS = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_NULLS,
    ST_MINOR,
    ST_ROW,
    ST_RAM_MAJOR,
    ST_RAM_OFFSET,
    ST_RAM_ROW,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [63:0] type_frames_lo;
    logic [23:0] type_frames_hi;
    logic [8:0]  ram_frames;
    logic [15:0] row_frames;
    logic [16:0] ram_row_offset;
    logic [15:0] ram_row_frames;
    logic [47:0] null_areas;
  } cfg_t;

  typedef struct packed {
    logic             clear;
    logic             add;
    logic             finish;
    logic             valid;
    logic [ACC_W-1:0] addend;
  } acc_ctrl_t;

  function automatic logic [7:0] frames_of(input logic [KIND_W-1:0] kind,
                                           input logic [63:0] lo,
                                           input logic [23:0] hi);
    logic [7:0] f;
    unique case (kind)
      4'd1:    f = lo[15:8];
      4'd2:    f = lo[23:16];
      4'd3:    f = lo[31:24];
      4'd4:    f = lo[39:32];
      4'd5:    f = lo[47:40];
      4'd6:    f = lo[55:48];
      4'd7:    f = lo[63:56];
      4'd8:    f = hi[7:0];
      4'd9:    f = hi[15:8];
      4'd10:   f = hi[23:16];
      default: f = lo[7:0];
    endcase
    return f;
  endfunction

endpackage

/* hw/rtl/fati_column_table.sv */
module fati_column_table (
  input  logic                                clk,
  input  logic                                we,
  input  logic [fati_pkg::COL_AW-1:0]         wr_addr,
  input  logic [fati_pkg::KIND_W-1:0]         wr_kind,
  input  logic [fati_pkg::COL_AW-1:0]         rd_addr,
  output logic [fati_pkg::KIND_W-1:0]         rd_kind
);

  logic [fati_pkg::KIND_W-1:0] mem [fati_pkg::COLUMNS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_kind;
    end
    rd_kind <= mem[rd_addr];
  end

endmodule

/* hw/rtl/fati_accum.sv */
module fati_accum (
  input  logic                             clk,
  input  logic                             rst,
  input  fati_pkg::acc_ctrl_t              ctrl,
  output logic                             done,
  output logic [fati_pkg::INDEX_W-1:0]     frame_index,
  output logic                             index_valid
);

  logic [fati_pkg::ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.add) begin
      acc <= acc + ctrl.addend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.finish;
    end
  end

  // saturate on the way out
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      if (acc > fati_pkg::INDEX_MAX) begin
        frame_index <= fati_pkg::INDEX_MAX[fati_pkg::INDEX_W-1:0];
      end else begin
        frame_index <= acc[fati_pkg::INDEX_W-1:0];
      end
      index_valid <= ctrl.valid;
    end
  end

endmodule

/* hw/rtl/fati_seq.sv */
module fati_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             lookup,
  input  logic [1:0]                       block_type,
  input  logic [7:0]                       major_address,
  input  logic [7:0]                       minor_address,
  input  logic [3:0]                       row_region,
  input  fati_pkg::cfg_t                   cfg,
  output logic [fati_pkg::COL_AW-1:0]      rd_addr,
  input  logic [fati_pkg::KIND_W-1:0]      rd_kind,
  output logic                             busy,
  output fati_pkg::acc_ctrl_t              ctrl
);

  localparam int AW = fati_pkg::ACC_W;
  localparam int PW = fati_pkg::POS_W;

  fati_pkg::state_t state, state_next;

  logic [1:0]    blk;
  logic [7:0]    major;
  logic [7:0]    minor;
  logic [3:0]    row;
  logic          invalid, invalid_next;
  logic [7:0]    s, s_next;
  logic [PW-1:0] p, p_next;
  logic [8:0]    nulls, nulls_next;
  logic          after_skip, after_skip_next;
  logic [1:0]    nidx, nidx_next;
  logic [fati_pkg::KIND_W-1:0] kind;
  logic [15:0]   area;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fati_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    s          <= s_next;
    p          <= p_next;
    nulls      <= nulls_next;
    after_skip <= after_skip_next;
    nidx       <= nidx_next;
    invalid    <= invalid_next;
    if (lookup && state == fati_pkg::ST_IDLE) begin
      blk   <= block_type;
      major <= major_address;
      minor <= minor_address;
      row   <= row_region;
    end
  end

  // positions past the table read as logic columns
  assign kind = (32'(p) < 32'(fati_pkg::COLUMNS)) ? rd_kind : '0;
  assign rd_addr = p_next[fati_pkg::COL_AW-1:0];
  assign busy = (state != fati_pkg::ST_IDLE);

  always_comb begin
    unique case (nidx)
      2'd0:    area = cfg.null_areas[15:0];
      2'd1:    area = cfg.null_areas[31:16];
      default: area = cfg.null_areas[47:32];
    endcase
  end

  always_comb begin
    state_next      = state;
    s_next          = s;
    p_next          = p;
    nulls_next      = nulls;
    after_skip_next = after_skip;
    nidx_next       = nidx;
    invalid_next    = invalid;
    ctrl            = '0;
    unique case (state)
      fati_pkg::ST_IDLE: begin
        if (lookup) begin
          ctrl.clear      = 1'b1;
          s_next          = '0;
          p_next          = '0;
          nulls_next      = '0;
          after_skip_next = 1'b0;
          nidx_next       = '0;
          invalid_next    = 1'b0;
          priority if (block_type == fati_pkg::BLK_LOGIC) begin
            state_next = fati_pkg::ST_WALK;
          end else if (block_type == fati_pkg::BLK_RAM) begin
            state_next = fati_pkg::ST_MINOR;
          end else begin
            invalid_next = 1'b1;
            state_next   = fati_pkg::ST_FINISH;
          end
        end
      end
      fati_pkg::ST_WALK: begin
        if (!after_skip && kind == fati_pkg::KIND_NULL) begin
          // skip one null column, then read the next position in the same step
          nulls_next = nulls + 9'd1;
          p_next     = p + PW'(1);
          if (s == major) begin
            state_next = fati_pkg::ST_NULLS;
          end else begin
            after_skip_next = 1'b1;
          end
        end else begin
          if (s < major) begin
            ctrl.add    = 1'b1;
            ctrl.addend = AW'(fati_pkg::frames_of(kind, cfg.type_frames_lo,
                                                  cfg.type_frames_hi));
          end
          if (s == major) begin
            state_next = fati_pkg::ST_NULLS;
          end else begin
            s_next          = s + 8'd1;
            p_next          = p + PW'(1);
            after_skip_next = 1'b0;
          end
        end
      end
      fati_pkg::ST_NULLS: begin
        if (nulls >= 9'd1 && nulls <= 9'd3 && 9'(nidx) < nulls) begin
          ctrl.add    = 1'b1;
          ctrl.addend = AW'(area);
        end
        if (nidx == 2'd2) begin
          state_next = fati_pkg::ST_MINOR;
        end else begin
          nidx_next = nidx + 2'd1;
        end
      end
      fati_pkg::ST_MINOR: begin
        ctrl.add    = 1'b1;
        ctrl.addend = AW'(minor);
        if (blk == fati_pkg::BLK_LOGIC) begin
          state_next = fati_pkg::ST_ROW;
        end else begin
          state_next = fati_pkg::ST_RAM_MAJOR;
        end
      end
      fati_pkg::ST_ROW: begin
        ctrl.add    = 1'b1;
        ctrl.addend = AW'(row) * AW'(cfg.row_frames);
        state_next  = fati_pkg::ST_FINISH;
      end
      fati_pkg::ST_RAM_MAJOR: begin
        ctrl.add    = 1'b1;
        ctrl.addend = AW'(major) * AW'(cfg.ram_frames);
        state_next  = fati_pkg::ST_RAM_OFFSET;
      end
      fati_pkg::ST_RAM_OFFSET: begin
        ctrl.add    = 1'b1;
        ctrl.addend = AW'(cfg.ram_row_offset);
        state_next  = fati_pkg::ST_RAM_ROW;
      end
      fati_pkg::ST_RAM_ROW: begin
        ctrl.add    = 1'b1;
        ctrl.addend = AW'(row) * AW'(cfg.ram_row_frames);
        state_next  = fati_pkg::ST_FINISH;
      end
      fati_pkg::ST_FINISH: begin
        ctrl.finish = 1'b1;
        ctrl.valid  = !invalid;
        state_next  = fati_pkg::ST_IDLE;
      end
      default: begin
        state_next = fati_pkg::ST_IDLE;
      end
    endcase
  end

  a_pos_tracks_walk: assert property (@(posedge clk) disable iff (rst)
    state == fati_pkg::ST_WALK |-> p == PW'(s) + PW'(nulls))
    else $error("walk position out of step with column count and null skips");

  a_nulls_bounded: assert property (@(posedge clk) disable iff (rst)
    state == fati_pkg::ST_WALK |-> nulls <= 9'(s) + 9'd1)
    else $error("more null columns skipped than walk steps");

  a_skip_has_null: assert property (@(posedge clk) disable iff (rst)
    state == fati_pkg::ST_WALK && after_skip |-> nulls != 9'd0)
    else $error("skip phase without a skipped null column");

  a_finish_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == fati_pkg::ST_FINISH |=> state == fati_pkg::ST_IDLE)
    else $error("finish state did not return to idle");

  a_clear_only_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |-> state == fati_pkg::ST_IDLE)
    else $error("accumulator cleared in the middle of a transaction");

endmodule

/* hw/rtl/frame_address_to_linear_index.sv */
// Frame address to linear frame index converter.
// Command channel: a transaction is taken at a clock edge with start high and
// busy low. command selects a column table write (column_slot, column_kind) or
// a lookup (block_type, major_address, minor_address, row_region).
// A write completes at the accepting edge and returns no result.
// A lookup returns one result: done is high for exactly one cycle with
// frame_index and index_valid; the receiver cannot hold it off.
// A logic-block lookup walks one step for each column up to and including
// major_address, plus one for each null column skipped before the last
// walk step. The walk reads one table entry per cycle; three null-offset
// steps, a minor step, a row step and a finish step follow on the shared
// adder. A block-RAM lookup takes minor, RAM major, RAM offset, RAM row and
// finish steps; an invalid block type goes straight to the finish step.
// busy is high from the accepting edge until done is raised; a new
// transaction may be started in the cycle done is high.
// Configuration registers must be written through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
// Reset restores defaults and idle; table entries hold nothing until written.
module frame_address_to_linear_index (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               command,
  input  logic [7:0]                         column_slot,
  input  logic [3:0]                         column_kind,
  input  logic [1:0]                         block_type,
  input  logic [7:0]                         major_address,
  input  logic [7:0]                         minor_address,
  input  logic [3:0]                         row_region,
  output logic                               done,
  output logic [23:0]                        frame_index,
  output logic                               index_valid,
  input  logic                               cfg_we,
  input  logic [fati_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [fati_pkg::CFG_DW-1:0]        cfg_data
);

  fati_pkg::cfg_t      cfg;
  fati_pkg::acc_ctrl_t ctrl;
  logic                accept;
  logic                lookup;
  logic                tbl_we;
  logic [fati_pkg::COL_AW-1:0] rd_addr;
  logic [fati_pkg::KIND_W-1:0] rd_kind;

  assign accept = start && !busy;
  assign lookup = accept && command == fati_pkg::CMD_LOOKUP;
  // drop writes to slots past the table
  assign tbl_we = accept && command == fati_pkg::CMD_WRITE &&
                  32'(column_slot) < 32'(fati_pkg::COLUMNS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.type_frames_lo <= 64'h090A_4C08_1000_0610;
      cfg.type_frames_hi <= 24'd4;
      cfg.ram_frames     <= 9'd256;
      cfg.row_frames     <= 16'd6850;
      cfg.ram_row_offset <= 17'd47950;
      cfg.ram_row_frames <= 16'd3330;
      cfg.null_areas     <= 48'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fati_pkg::CFG_TYPE_LO:    cfg.type_frames_lo <= cfg_data;
        fati_pkg::CFG_TYPE_HI:    cfg.type_frames_hi <= cfg_data[23:0];
        fati_pkg::CFG_RAM_FRAMES: cfg.ram_frames     <= cfg_data[8:0];
        fati_pkg::CFG_ROW_FRAMES: cfg.row_frames     <= cfg_data[15:0];
        fati_pkg::CFG_RAM_OFFSET: cfg.ram_row_offset <= cfg_data[16:0];
        fati_pkg::CFG_RAM_ROWS:   cfg.ram_row_frames <= cfg_data[15:0];
        fati_pkg::CFG_NULL_AREAS: cfg.null_areas     <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  fati_column_table u_table (
    .clk     (clk),
    .we      (tbl_we),
    .wr_addr (fati_pkg::COL_AW'(column_slot)),
    .wr_kind (column_kind),
    .rd_addr (rd_addr),
    .rd_kind (rd_kind)
  );

  fati_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .lookup        (lookup),
    .block_type    (block_type),
    .major_address (major_address),
    .minor_address (minor_address),
    .row_region    (row_region),
    .cfg           (cfg),
    .rd_addr       (rd_addr),
    .rd_kind       (rd_kind),
    .busy          (busy),
    .ctrl          (ctrl)
  );

  fati_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .done        (done),
    .frame_index (frame_index),
    .index_valid (index_valid)
  );

endmodule

/* tb/fati_tb_pkg.sv */
package fati_tb_pkg;

  typedef enum logic [3:0] {
    COL_LOGIC,
    COL_INTERCONNECT,
    COL_CLOCK,
    COL_LOGIC_M,
    COL_DSP,
    COL_SWITCH,
    COL_PRIMITIVE,
    COL_IO,
    COL_MATRIX,
    COL_FIFO,
    COL_VFRAME,
    COL_NULL,
    COL_SPARE12,
    COL_SPARE13,
    COL_SPARE14,
    COL_SPARE15
  } col_kind_e;

  localparam logic [1:0] BLK_SPARE2 = 2'd2;
  localparam logic [1:0] BLK_SPARE3 = 2'd3;

endpackage

/* tb/frame_index_checker.sv */
module frame_index_checker
  import fati_pkg::*;
  import fati_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              command,
  input  logic [7:0]        column_slot,
  input  logic [3:0]        column_kind,
  input  logic [1:0]        block_type,
  input  logic [7:0]        major_address,
  input  logic [7:0]        minor_address,
  input  logic [3:0]        row_region,
  input  logic              done,
  input  logic [23:0]       frame_index,
  input  logic              index_valid,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output int                mismatches,
  output int                outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] frame_index;
    logic        index_valid;
  } frame_result_t;

  localparam cfg_t SETTINGS_AT_RESET = '{
    type_frames_lo: 64'h090A_4C08_1000_0610,
    type_frames_hi: 24'd4,
    ram_frames:     9'd256,
    row_frames:     16'd6850,
    ram_row_offset: 17'd47950,
    ram_row_frames: 16'd3330,
    null_areas:     48'd0
  };

  cfg_t          settings;
  col_kind_e     column_map [COLUMNS];
  frame_result_t pending_frames [$];
  frame_result_t want;
  int            error_count = 0;
  int            pending_count = 0;

  assign mismatches  = error_count;
  assign outstanding = pending_count;

  // Positions past the end of the table behave as logic columns.
  function automatic col_kind_e column_at(input int unsigned pos);
    if (pos >= COLUMNS) begin
      return COL_LOGIC;
    end
    return column_map[pos];
  endfunction

  function automatic logic [63:0] column_frames(input col_kind_e k);
    if (k < COL_MATRIX) begin
      return 64'(settings.type_frames_lo[8*int'(k) +: 8]);
    end else if (k < COL_NULL) begin
      return 64'(settings.type_frames_hi[8*(int'(k) - int'(COL_MATRIX)) +: 8]);
    end
    return 64'(settings.type_frames_lo[7:0]);
  endfunction

  function automatic frame_result_t linear_frame(input logic [1:0] blk,
                                                 input logic [7:0] major,
                                                 input logic [7:0] minor,
                                                 input logic [3:0] row);
    frame_result_t res;
    int unsigned   per_kind [11];
    int unsigned   nulls;
    int unsigned   special;
    col_kind_e     k;
    logic [63:0]   sum;
    res = '0;
    sum = '0;
    nulls = 0;
    special = 0;
    foreach (per_kind[i]) per_kind[i] = 0;
    if (blk == BLK_LOGIC) begin
      // Skip at most one null column per step; a null seen as the counted
      // column falls through as logic.
      for (int unsigned step = 0; step <= major; step++) begin
        if (column_at(step + nulls) == COL_NULL) begin
          nulls++;
        end
        if (step < major) begin
          k = column_at(step + nulls);
          if (k >= COL_INTERCONNECT && k <= COL_VFRAME) begin
            per_kind[int'(k)]++;
          end
        end
      end
      for (int i = int'(COL_INTERCONNECT); i <= int'(COL_VFRAME); i++) begin
        sum += 64'(per_kind[i]) * column_frames(col_kind_e'(i));
        special += per_kind[i];
      end
      sum += 64'(int'(major) - int'(special)) * column_frames(COL_LOGIC);
      if (nulls >= 1 && nulls <= 3) begin
        for (int i = 0; i < int'(nulls); i++) begin
          sum += 64'(settings.null_areas[16*i +: 16]);
        end
      end
      sum += 64'(minor) + 64'(row) * 64'(settings.row_frames);
    end else if (blk == BLK_RAM) begin
      sum = 64'(minor) + 64'(major) * 64'(settings.ram_frames)
          + 64'(settings.ram_row_offset) + 64'(row) * 64'(settings.ram_row_frames);
    end else begin
      return res;
    end
    res.frame_index = (sum > 64'(INDEX_MAX)) ? 24'hFF_FFFF : sum[23:0];
    res.index_valid = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      settings = SETTINGS_AT_RESET;
      pending_frames.delete();
    end else begin
      // Retire the oldest expectation before queuing one for this edge.
      if (done) begin
        if (pending_frames.size() == 0) begin
          error_count++;
          $display("%0t unexpected result: expected none, actual frame_index %0d index_valid %0b",
                   $time, frame_index, index_valid);
        end else begin
          want = pending_frames.pop_front();
          if (frame_index !== want.frame_index) begin
            error_count++;
            $display("%0t frame_index mismatch: expected %0d, actual %0d",
                     $time, want.frame_index, frame_index);
          end
          if (index_valid !== want.index_valid) begin
            error_count++;
            $display("%0t index_valid mismatch: expected %0b, actual %0b",
                     $time, want.index_valid, index_valid);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TYPE_LO:    settings.type_frames_lo = cfg_data;
          CFG_TYPE_HI:    settings.type_frames_hi = cfg_data[23:0];
          CFG_RAM_FRAMES: settings.ram_frames     = cfg_data[8:0];
          CFG_ROW_FRAMES: settings.row_frames     = cfg_data[15:0];
          CFG_RAM_OFFSET: settings.ram_row_offset = cfg_data[16:0];
          CFG_RAM_ROWS:   settings.ram_row_frames = cfg_data[15:0];
          CFG_NULL_AREAS: settings.null_areas     = cfg_data[47:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (command == CMD_WRITE) begin
          column_map[column_slot] = col_kind_e'(column_kind);
        end else begin
          pending_frames.push_back(linear_frame(block_type, major_address,
                                                minor_address, row_region));
        end
      end
    end
    pending_count = pending_frames.size();
  end

endmodule

/* tb/tb_frame_address_to_linear_index.sv */
module tb_frame_address_to_linear_index;
  timeunit 1ns;
  timeprecision 1ps;

  import fati_pkg::*;
  import fati_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 600;
  localparam int PHASE_ITEMS    = 180;

  localparam int SET_MAX    = 0;
  localparam int SET_ZERO   = 1;
  localparam int SET_RANDOM = 2;

  localparam int IDLE_PLAN [6] = '{0, 68, 0, 29, 68, 29};

  localparam logic [CFG_IW-1:0] REGISTER_IDS [7] = '{
    CFG_TYPE_LO, CFG_TYPE_HI, CFG_RAM_FRAMES, CFG_ROW_FRAMES,
    CFG_RAM_OFFSET, CFG_RAM_ROWS, CFG_NULL_AREAS
  };

  // Leading table contents: a double null, every special kind, and three more
  // nulls with undefined kinds between them.
  localparam col_kind_e SEEDED_COLUMNS [17] = '{
    COL_NULL, COL_NULL, COL_INTERCONNECT, COL_CLOCK, COL_LOGIC_M, COL_DSP,
    COL_SWITCH, COL_PRIMITIVE, COL_IO, COL_MATRIX, COL_FIFO, COL_VFRAME,
    COL_NULL, COL_SPARE12, COL_NULL, COL_SPARE15, COL_NULL
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic              command;
  logic [7:0]        column_slot;
  logic [3:0]        column_kind;
  logic [1:0]        block_type;
  logic [7:0]        major_address;
  logic [7:0]        minor_address;
  logic [3:0]        row_region;
  logic              done;
  logic [23:0]       frame_index;
  logic              index_valid;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  int                mismatches;
  int                outstanding;
  int                idle_pct;
  int                quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_address_to_linear_index u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .column_slot   (column_slot),
    .column_kind   (column_kind),
    .block_type    (block_type),
    .major_address (major_address),
    .minor_address (minor_address),
    .row_region    (row_region),
    .done          (done),
    .frame_index   (frame_index),
    .index_valid   (index_valid),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  frame_index_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .column_slot   (column_slot),
    .column_kind   (column_kind),
    .block_type    (block_type),
    .major_address (major_address),
    .minor_address (minor_address),
    .row_region    (row_region),
    .done          (done),
    .frame_index   (frame_index),
    .index_valid   (index_valid),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic col_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) begin
      return COL_NULL;
    end
    if (r < 30) begin
      return col_kind_e'($urandom_range(int'(COL_SPARE15), int'(COL_SPARE12)));
    end
    return col_kind_e'($urandom_range(int'(COL_VFRAME), int'(COL_LOGIC)));
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic issue(input logic cmd, input logic [7:0] slot, input logic [3:0] kind,
                       input logic [1:0] blk, input logic [7:0] major,
                       input logic [7:0] minor, input logic [3:0] row);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    command       <= cmd;
    column_slot   <= slot;
    column_kind   <= kind;
    block_type    <= blk;
    major_address <= major;
    minor_address <= minor;
    row_region    <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || busy);
    repeat (5) @(posedge clk);
  endtask

  task automatic load_settings(input int mode);
    foreach (REGISTER_IDS[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= REGISTER_IDS[i];
      case (mode)
        SET_MAX:  cfg_data <= '1;
        SET_ZERO: cfg_data <= '0;
        default:  cfg_data <= {$urandom, $urandom};
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic directed_lookups();
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_LOGIC, 8'd0, 8'd0, 4'd0);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_LOGIC, 8'd1, 8'd1, 4'd1);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_LOGIC, 8'd2, 8'd255, 4'd15);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_LOGIC, 8'd12, 8'd7, 4'd3);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_LOGIC, 8'd14, 8'd0, 4'd15);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_LOGIC, 8'd16, 8'd128, 4'd8);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_LOGIC, 8'd255, 8'd255, 4'd15);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_LOGIC, 8'd255, 8'd0, 4'd0);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_RAM, 8'd0, 8'd0, 4'd0);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_RAM, 8'd255, 8'd255, 4'd15);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_SPARE2, 8'd255, 8'd255, 4'd15);
    issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), BLK_SPARE3, 8'd0, 8'd0, 4'd0);
  endtask

  initial begin
    int unsigned pick;
    logic [1:0]  blk;
    logic [7:0]  major;
    rst           <= 1'b1;
    start         <= 1'b0;
    command       <= CMD_WRITE;
    column_slot   <= '0;
    column_kind   <= '0;
    block_type    <= BLK_LOGIC;
    major_address <= '0;
    minor_address <= '0;
    row_region    <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_TYPE_LO;
    cfg_data      <= '0;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole column table before any lookup reads it.
    for (int slot = 0; slot < COLUMNS; slot++) begin
      issue(CMD_WRITE, 8'(slot), (slot < 17) ? SEEDED_COLUMNS[slot] : pick_kind(),
            2'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
    end
    directed_lookups();
    wait_for_results();
    load_settings(SET_MAX);
    directed_lookups();
    wait_for_results();
    load_settings(SET_ZERO);
    directed_lookups();

    for (int phase = 0; phase < 6; phase++) begin
      wait_for_results();
      load_settings(SET_RANDOM);
      idle_pct = IDLE_PLAN[phase];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          wait_for_results();
        end
        pick = $urandom_range(99);
        if (pick < 25) begin
          issue(CMD_WRITE, 8'($urandom), pick_kind(), 2'($urandom), 8'($urandom),
                8'($urandom), 4'($urandom));
        end else begin
          pick = $urandom_range(99);
          if (pick < 70) begin
            blk = BLK_LOGIC;
          end else if (pick < 85) begin
            blk = BLK_RAM;
          end else begin
            blk = 2'($urandom_range(BLK_SPARE3, BLK_SPARE2));
          end
          // Keep most walks short; a share still spans the full table.
          major = ($urandom_range(99) < 60) ? 8'($urandom_range(31))
                                            : 8'($urandom_range(255));
          issue(CMD_LOOKUP, 8'($urandom), 4'($urandom), blk, major, 8'($urandom),
                4'($urandom));
        end
      end
    end

    idle_pct = 0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
